// ===== hdl/cbm_pkg.sv =====
// Package for the cartridge bank mapper: access codes, result and bank
// state structs, address map constants and parameter defaults.
// No dependencies.
`timescale 1ns / 1ps

package cbm_pkg;

  // Field widths
  localparam int ADDR_W   = 16;
  localparam int DATA_W   = 8;
  localparam int TARGET_W = 22;
  localparam int KIND_W   = 2;

  // Parameter defaults
  localparam int unsigned DIVIDER_ADDR_DEF    = 65284;
  localparam int unsigned TIMER_CTRL_ADDR_DEF = 65287;
  localparam int unsigned RAM_BANK_BYTES_DEF  = 8192;

  // Controller kinds written through the configuration port
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MBC1 = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MBC2 = 2'd2;

  // CPU access kinds
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Address map
  localparam logic [ADDR_W-1:0] ROM_BANKX_BASE = 16'h4000;
  localparam logic [ADDR_W-1:0] VRAM_BASE      = 16'h8000;
  localparam logic [ADDR_W-1:0] XRAM_BASE      = 16'hA000;
  localparam logic [ADDR_W-1:0] WRAM1_BASE     = 16'hC000;
  localparam logic [ADDR_W-1:0] ECHO_BASE      = 16'hE000;
  localparam logic [ADDR_W-1:0] OAM_BASE       = 16'hFE00;
  localparam logic [ADDR_W-1:0] RSVD_BASE      = 16'hFEA0;
  localparam logic [ADDR_W-1:0] IO_BASE        = 16'hFF00;
  localparam logic [ADDR_W-1:0] ECHO_OFFSET    = 16'h2000;
  localparam logic [ADDR_W-1:0] ROM_LOW_BASE   = 16'h2000;
  localparam logic [ADDR_W-1:0] ROM_HIGH_BASE  = 16'h6000;

  // RAM enable nibble values
  localparam logic [3:0] RAM_EN_CODE  = 4'hA;
  localparam logic [3:0] RAM_DIS_CODE = 4'h0;

  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_RD_INT   = 3'd1,
    ACT_RD_CART  = 3'd2,
    ACT_RD_XRAM  = 3'd3,
    ACT_WR_INT   = 3'd4
  } action_t;

  typedef struct packed {
    action_t               action;
    logic [TARGET_W-1:0]   target_address;
    logic [DATA_W-1:0]     write_value;
    logic                  timer_rate_changed;
    logic                  last;
  } result_t;

  typedef struct packed {
    logic [7:0] rom_bank;
    logic [1:0] ram_bank;
    logic       rom_mode;
    logic       ram_enabled;
  } bank_state_t;

endpackage

// ===== hdl/cartridge_bank_mapper_core.sv =====
// Top level of the cartridge bank mapper: input register, bank state,
// result register with a second-beat slot. Depends on cbm_pkg, cbm_translate.
`timescale 1ns / 1ps

// Usage
//   in_*  : one CPU access per beat. in_tuser = op (0 read, 1 write),
//           in_tdata = bus_address, bus_data.
//   out_* : translated accesses. out_tuser = action, out_tdata =
//           target_address, write_value, timer_rate_changed; out_tlast
//           marks the final beat of an access.
//   cfg_* : cfg_we writes cfg_wdata into the controller kind register;
//           write only while no access is in flight.
// Timing
//   An accepted access passes the input register, then the result register,
//   before its first result shows. One access per cycle is sustained while
//   out_tready stays high; an echo write with RAM enabled yields two output
//   beats, and the next access waits until the second beat has left its slot.
// Reset
//   rst_n low clears both stages, sets ROM bank 1, RAM bank 0, ROM mode,
//   RAM disabled, controller kind none.
// Stall
//   When out_tready is low the result holds; the input register keeps
//   one beat, and in_tready drops once it is full.

module cartridge_bank_mapper_core #(
  parameter int unsigned DIVIDER_ADDR    = cbm_pkg::DIVIDER_ADDR_DEF,
  parameter int unsigned TIMER_CTRL_ADDR = cbm_pkg::TIMER_CTRL_ADDR_DEF,
  parameter int unsigned RAM_BANK_BYTES  = cbm_pkg::RAM_BANK_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_we,
  input  logic [cbm_pkg::KIND_W-1:0]   cfg_wdata,   // controller_kind
  // access stream
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [23:0]                  in_tdata,    // bus_address[15:0], bus_data[23:16]
  input  logic                         in_tuser,    // op
  // result stream
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [31:0]                  out_tdata,   // target_address[21:0],
                                                    // write_value[29:22],
                                                    // timer_rate_changed[30], pad[31]
  output logic [2:0]                   out_tuser,   // action
  output logic                         out_tlast    // last
);

  logic [cbm_pkg::KIND_W-1:0]   kind_r;
  cbm_pkg::bank_state_t         state_r, state_nxt, state_calc;

  logic                         s1_valid_r, s1_valid_nxt;
  logic                         s1_op_r;
  logic [cbm_pkg::ADDR_W-1:0]   s1_addr_r;
  logic [cbm_pkg::DATA_W-1:0]   s1_data_r;

  logic                         out_valid_r, out_valid_nxt;
  cbm_pkg::result_t             out_res_r, out_res_nxt;
  logic                         pend_valid_r, pend_valid_nxt;
  cbm_pkg::result_t             pend_res_r, pend_res_nxt;

  cbm_pkg::result_t             res0, res1;
  logic                         two_beats;
  logic                         in_fire, out_fire, out_free, s1_adv;

  // Handshake
  assign out_fire  = out_valid_r && out_tready;
  assign out_free  = !pend_valid_r && (!out_valid_r || out_tready);
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  cbm_translate #(
    .DIVIDER_ADDR    (DIVIDER_ADDR),
    .TIMER_CTRL_ADDR (TIMER_CTRL_ADDR),
    .RAM_BANK_BYTES  (RAM_BANK_BYTES)
  ) u_translate (
    .op        (s1_op_r),
    .addr      (s1_addr_r),
    .data      (s1_data_r),
    .kind      (kind_r),
    .state     (state_r),
    .state_nxt (state_calc),
    .res0      (res0),
    .res1      (res1),
    .two_beats (two_beats)
  );

  // Next values for the pipeline and the bank state
  always_comb begin
    s1_valid_nxt   = s1_valid_r;
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r;
    out_res_nxt    = out_res_r;
    pend_valid_nxt = pend_valid_r;
    pend_res_nxt   = pend_res_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    if (s1_adv) begin
      state_nxt      = state_calc;
      out_valid_nxt  = 1'b1;
      out_res_nxt    = res0;
      pend_valid_nxt = two_beats;
      pend_res_nxt   = res1;
    end else if (out_fire) begin
      if (pend_valid_r) begin
        out_res_nxt    = pend_res_r;
        pend_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r       <= cbm_pkg::KIND_NONE;
      state_r      <= '{rom_bank: 8'd1, ram_bank: 2'd0, rom_mode: 1'b1,
                        ram_enabled: 1'b0};
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        kind_r <= cfg_wdata;
      end
      state_r      <= state_nxt;
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r   <= in_tuser;
      s1_addr_r <= in_tdata[15:0];
      s1_data_r <= in_tdata[23:16];
    end
    out_res_r  <= out_res_nxt;
    pend_res_r <= pend_res_nxt;
  end

  // Output beat
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.action;
  assign out_tlast  = out_res_r.last;
  assign out_tdata  = {1'b0, out_res_r.timer_rate_changed, out_res_r.write_value,
                       out_res_r.target_address};

endmodule

// ===== hdl/cbm_translate.sv =====
// Combinational access decode: bank register update and address
// translation for one CPU access. Depends on cbm_pkg.
`timescale 1ns / 1ps

module cbm_translate #(
  parameter int unsigned DIVIDER_ADDR    = cbm_pkg::DIVIDER_ADDR_DEF,
  parameter int unsigned TIMER_CTRL_ADDR = cbm_pkg::TIMER_CTRL_ADDR_DEF,
  parameter int unsigned RAM_BANK_BYTES  = cbm_pkg::RAM_BANK_BYTES_DEF
) (
  input  logic                            op,
  input  logic [cbm_pkg::ADDR_W-1:0]      addr,
  input  logic [cbm_pkg::DATA_W-1:0]      data,
  input  logic [cbm_pkg::KIND_W-1:0]      kind,
  input  cbm_pkg::bank_state_t            state,
  output cbm_pkg::bank_state_t            state_nxt,
  output cbm_pkg::result_t                res0,
  output cbm_pkg::result_t                res1,
  output logic                            two_beats
);

  logic                           m1;
  logic                           m2;
  logic [7:0]                     bank_cand;
  logic [cbm_pkg::TARGET_W-1:0]   xram_target;
  logic [cbm_pkg::ADDR_W-1:0]     echo_mirror;

  assign m1 = (kind == cbm_pkg::KIND_MBC1);
  assign m2 = (kind == cbm_pkg::KIND_MBC2);

  assign xram_target = cbm_pkg::TARGET_W'(addr[12:0])
                     + cbm_pkg::TARGET_W'(state.ram_bank)
                     * cbm_pkg::TARGET_W'(RAM_BANK_BYTES);
  assign echo_mirror = addr - cbm_pkg::ECHO_OFFSET;

  // Bank register update on writes below the video area
  always_comb begin
    state_nxt = state;
    bank_cand = state.rom_bank;
    if (op == cbm_pkg::OP_WRITE && addr < cbm_pkg::VRAM_BASE) begin
      if (addr < cbm_pkg::ROM_LOW_BASE) begin
        // RAM enable; MBC2 skips it when address bit 4 is set
        if ((m1 || (m2 && !addr[4]))) begin
          if (data[3:0] == cbm_pkg::RAM_EN_CODE) begin
            state_nxt.ram_enabled = 1'b1;
          end else if (data[3:0] == cbm_pkg::RAM_DIS_CODE) begin
            state_nxt.ram_enabled = 1'b0;
          end
        end
      end else if (addr < cbm_pkg::ROM_BANKX_BASE) begin
        // Low ROM bank bits, bank zero maps to one
        if (m1 || m2) begin
          bank_cand = m1 ? {state.rom_bank[7:5], data[4:0]} : {4'd0, data[3:0]};
          state_nxt.rom_bank = (bank_cand == 8'd0) ? 8'd1 : bank_cand;
        end
      end else if (addr < cbm_pkg::ROM_HIGH_BASE) begin
        // High ROM bits in ROM mode, else RAM bank select
        if (m1) begin
          if (state.rom_mode) begin
            bank_cand = {data[7:5], state.rom_bank[4:0]};
            state_nxt.rom_bank = (bank_cand == 8'd0) ? 8'd1 : bank_cand;
          end else begin
            state_nxt.ram_bank = data[1:0];
          end
        end
      end else begin
        // Mode select; entering ROM mode clears the RAM bank
        if (m1) begin
          state_nxt.rom_mode = !data[0];
          if (!data[0]) begin
            state_nxt.ram_bank = 2'd0;
          end
        end
      end
    end
  end

  // Result beats
  always_comb begin
    res0 = '{action: cbm_pkg::ACT_NONE, target_address: '0, write_value: '0,
             timer_rate_changed: 1'b0, last: 1'b1};
    res1 = res0;
    two_beats = 1'b0;
    if (op == cbm_pkg::OP_READ) begin
      if (addr >= cbm_pkg::ROM_BANKX_BASE && addr < cbm_pkg::VRAM_BASE) begin
        res0.action         = cbm_pkg::ACT_RD_CART;
        res0.target_address = {state.rom_bank, addr[13:0]};
      end else if (addr >= cbm_pkg::XRAM_BASE && addr < cbm_pkg::WRAM1_BASE) begin
        res0.action         = cbm_pkg::ACT_RD_XRAM;
        res0.target_address = xram_target;
      end else begin
        res0.action         = cbm_pkg::ACT_RD_INT;
        res0.target_address = cbm_pkg::TARGET_W'(addr);
      end
    end else if (addr < cbm_pkg::VRAM_BASE) begin
      // bank register write: nothing stored
    end else if (addr >= cbm_pkg::ECHO_BASE && addr < cbm_pkg::OAM_BASE) begin
      // echo area mirrors into work RAM when RAM is enabled
      if (state.ram_enabled) begin
        two_beats           = 1'b1;
        res0.action         = cbm_pkg::ACT_WR_INT;
        res0.target_address = cbm_pkg::TARGET_W'(addr);
        res0.write_value    = data;
        res0.last           = 1'b0;
        res1.action         = cbm_pkg::ACT_WR_INT;
        res1.target_address = cbm_pkg::TARGET_W'(echo_mirror);
        res1.write_value    = data;
      end
    end else if (addr >= cbm_pkg::RSVD_BASE && addr < cbm_pkg::IO_BASE) begin
      // restricted area: dropped
    end else begin
      res0.action         = cbm_pkg::ACT_WR_INT;
      res0.target_address = cbm_pkg::TARGET_W'(addr);
      if (addr == cbm_pkg::ADDR_W'(DIVIDER_ADDR)) begin
        res0.write_value = '0;
      end else begin
        res0.write_value        = data;
        res0.timer_rate_changed = (addr == cbm_pkg::ADDR_W'(TIMER_CTRL_ADDR));
      end
    end
  end

endmodule

// ===== verif/cartridge_bank_mapper_core_test.sv =====
// Self-checking testbench for cartridge_bank_mapper_core: directed and random CPU
// accesses under every controller kind, checked beat by beat by a bank-state predictor.
// Depends on cbm_pkg and the cartridge_bank_mapper_core RTL.
`timescale 1ns / 1ps

module cartridge_bank_mapper_core_test;

  // Spare controller code; the block treats it as no controller
  localparam logic [cbm_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int unsigned ROM_BANK_BYTES = 'h4000;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASES = 9;
  localparam int PHASE_ACCESSES = 155;

  // Predicts translated accesses from its own copy of the bank registers
  class bank_map_scoreboard;
    logic [cbm_pkg::KIND_W-1:0] kind;
    logic [7:0]                 rom_bank;
    logic [1:0]                 ram_bank;
    logic                       rom_mode;
    logic                       ram_enabled;
    cbm_pkg::result_t           pending_q[$];
    int                         errors;

    function new();
      kind        = cbm_pkg::KIND_NONE;
      rom_bank    = 8'd1;
      ram_bank    = 2'd0;
      rom_mode    = 1'b1;
      ram_enabled = 1'b0;
      errors      = 0;
    endfunction

    function void set_kind(logic [cbm_pkg::KIND_W-1:0] k);
      kind = k;
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    // Register writes below 0x8000
    function void update_banks(logic [15:0] a, logic [7:0] d);
      bit mbc1;
      bit mbc2;
      mbc1 = (kind == cbm_pkg::KIND_MBC1);
      mbc2 = (kind == cbm_pkg::KIND_MBC2);
      if (a < cbm_pkg::ROM_LOW_BASE) begin
        // RAM enable; MBC2 decodes it only with address bit 4 clear
        if ((mbc1 || mbc2) && !(mbc2 && a[4])) begin
          if (d[3:0] == cbm_pkg::RAM_EN_CODE) ram_enabled = 1'b1;
          else if (d[3:0] == cbm_pkg::RAM_DIS_CODE) ram_enabled = 1'b0;
        end
      end else if (a < cbm_pkg::ROM_BANKX_BASE) begin
        if (mbc1) rom_bank = {rom_bank[7:5], d[4:0]};
        else if (mbc2) rom_bank = {4'h0, d[3:0]};
        if (rom_bank == 8'd0) rom_bank = 8'd1;
      end else if (a < cbm_pkg::ROM_HIGH_BASE) begin
        if (mbc1) begin
          if (rom_mode) begin
            rom_bank = {d[7:5], rom_bank[4:0]};
            if (rom_bank == 8'd0) rom_bank = 8'd1;
          end else begin
            ram_bank = d[1:0];
          end
        end
      end else if (mbc1) begin
        // mode select; going back to ROM mode drops the RAM bank
        rom_mode = !d[0];
        if (rom_mode) ram_bank = 2'd0;
      end
    endfunction

    // Called for every accepted access beat
    function void note_access(logic op, logic [15:0] a, logic [7:0] d);
      cbm_pkg::result_t r;
      int unsigned      t;
      r = '0;
      r.last = 1'b1;
      if (op == cbm_pkg::OP_READ) begin
        if (a >= cbm_pkg::ROM_BANKX_BASE && a < cbm_pkg::VRAM_BASE) begin
          t = 32'(a - cbm_pkg::ROM_BANKX_BASE) + 32'(rom_bank) * ROM_BANK_BYTES;
          r.action = cbm_pkg::ACT_RD_CART;
          r.target_address = t[cbm_pkg::TARGET_W-1:0];
        end else if (a >= cbm_pkg::XRAM_BASE && a < cbm_pkg::WRAM1_BASE) begin
          t = 32'(a - cbm_pkg::XRAM_BASE) + 32'(ram_bank) * cbm_pkg::RAM_BANK_BYTES_DEF;
          r.action = cbm_pkg::ACT_RD_XRAM;
          r.target_address = t[cbm_pkg::TARGET_W-1:0];
        end else begin
          r.action = cbm_pkg::ACT_RD_INT;
          r.target_address = cbm_pkg::TARGET_W'(a);
        end
      end else if (a < cbm_pkg::VRAM_BASE) begin
        update_banks(a, d);
      end else if (a >= cbm_pkg::ECHO_BASE && a < cbm_pkg::OAM_BASE) begin
        // echo write lands twice, only with RAM enabled
        if (ram_enabled) begin
          r.action = cbm_pkg::ACT_WR_INT;
          r.target_address = cbm_pkg::TARGET_W'(a);
          r.write_value = d;
          r.last = 1'b0;
          pending_q.push_back(r);
          r.target_address = cbm_pkg::TARGET_W'(a - cbm_pkg::ECHO_OFFSET);
          r.last = 1'b1;
        end
      end else if (a >= cbm_pkg::RSVD_BASE && a < cbm_pkg::IO_BASE) begin
        // restricted area: dropped
      end else if (a == cbm_pkg::DIVIDER_ADDR_DEF) begin
        r.action = cbm_pkg::ACT_WR_INT;
        r.target_address = cbm_pkg::TARGET_W'(a);
      end else begin
        r.action = cbm_pkg::ACT_WR_INT;
        r.target_address = cbm_pkg::TARGET_W'(a);
        r.write_value = d;
        r.timer_rate_changed = (a == cbm_pkg::TIMER_CTRL_ADDR_DEF);
      end
      pending_q.push_back(r);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    // Called for every accepted result beat
    function void check_beat(cbm_pkg::result_t got);
      cbm_pkg::result_t want;
      if (pending_q.size() == 0) begin
        $error("result beat with no access pending: action %0d target 0x%0h",
               got.action, got.target_address);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      check_field("action", 32'(want.action), 32'(got.action));
      check_field("target_address", 32'(want.target_address),
                  32'(got.target_address));
      check_field("write_value", 32'(want.write_value), 32'(got.write_value));
      check_field("timer_rate_changed", 32'(want.timer_rate_changed),
                  32'(got.timer_rate_changed));
      check_field("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [cbm_pkg::KIND_W-1:0]   cfg_wdata = '0;
  logic                         in_tvalid = 1'b0;
  logic                         in_tready;
  logic [23:0]                  in_tdata = '0;   // bus_address[15:0], bus_data[23:16]
  logic                         in_tuser = 1'b0; // op
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  logic [31:0]                  out_tdata;       // target_address[21:0], write_value[29:22],
                                                 // timer_rate_changed[30], pad[31]
  logic [2:0]                   out_tuser;       // action
  logic                         out_tlast;       // last

  bank_map_scoreboard sb = new();
  int snd_idle = 0;
  int rcv_idle = 0;
  int rcv_hold = 0;
  int quiet_cycles = 0;

  logic [cbm_pkg::KIND_W-1:0] phase_kind [0:PHASES-1] = '{
    cbm_pkg::KIND_MBC1, cbm_pkg::KIND_MBC2, cbm_pkg::KIND_MBC1,
    cbm_pkg::KIND_MBC2, cbm_pkg::KIND_NONE, cbm_pkg::KIND_MBC1,
    KIND_SPARE, cbm_pkg::KIND_MBC2, cbm_pkg::KIND_MBC1};

  cartridge_bank_mapper_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver: random back-pressure, or a long hold when requested
  always @(negedge clk) begin
    if (rcv_hold > 0) begin
      out_tready <= 1'b0;
      rcv_hold <= rcv_hold - 1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  // Beat monitor and stall watchdog
  always @(posedge clk) begin : monitor
    cbm_pkg::result_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_access(in_tuser, in_tdata[15:0], in_tdata[23:16]);
      if (out_tvalid && out_tready) begin
        got.action             = cbm_pkg::action_t'(out_tuser);
        got.target_address     = out_tdata[21:0];
        got.write_value        = out_tdata[29:22];
        got.timer_rate_changed = out_tdata[30];
        got.last               = out_tlast;
        sb.check_beat(got);
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one access beat; returns on the falling edge after it is taken
  task automatic send(logic op, logic [15:0] addr, logic [7:0] data);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {data, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering and wait for every pending result, plus pipeline slack
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(logic [cbm_pkg::KIND_W-1:0] k);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= k;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_kind(k);
  endtask

  // Random access, weighted toward the interesting regions
  task automatic make_access(output logic op, output logic [15:0] addr,
                             output logic [7:0] data);
    int sel;
    sel  = int'($urandom_range(0, 99));
    op   = cbm_pkg::OP_WRITE;
    addr = 16'($urandom_range(0, 16'hFFFF));
    data = 8'($urandom_range(0, 8'hFF));
    if (sel < 25) begin
      // bank register write; RAM-enable codes are common
      addr = 16'($urandom_range(0, cbm_pkg::VRAM_BASE - 1));
      if (addr < cbm_pkg::ROM_LOW_BASE && $urandom_range(0, 1))
        data[3:0] = $urandom_range(0, 1) ? cbm_pkg::RAM_EN_CODE : cbm_pkg::RAM_DIS_CODE;
    end else if (sel < 45) begin
      op   = cbm_pkg::OP_READ;
      addr = $urandom_range(0, 1)
           ? 16'($urandom_range(cbm_pkg::ROM_BANKX_BASE, cbm_pkg::VRAM_BASE - 1))
           : 16'($urandom_range(cbm_pkg::XRAM_BASE, cbm_pkg::WRAM1_BASE - 1));
    end else if (sel < 60) begin
      addr = 16'($urandom_range(cbm_pkg::ECHO_BASE, cbm_pkg::OAM_BASE - 1));
    end else if (sel < 65) begin
      addr = 16'($urandom_range(cbm_pkg::RSVD_BASE, cbm_pkg::IO_BASE - 1));
    end else if (sel < 72) begin
      op   = 1'($urandom_range(0, 1));
      addr = $urandom_range(0, 1) ? 16'(cbm_pkg::DIVIDER_ADDR_DEF)
                                  : 16'(cbm_pkg::TIMER_CTRL_ADDR_DEF);
    end else begin
      op = 1'($urandom_range(0, 1));
    end
  endtask

  initial begin
    logic        op;
    logic [15:0] addr;
    logic [7:0]  data;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    snd_idle = 11;
    rcv_idle = 71;

    // MBC1: reads of banked ROM, external RAM and high memory, every bank register, echo, special writes
    configure(cbm_pkg::KIND_MBC1);
    send(cbm_pkg::OP_READ,  16'h4000, 8'h00);
    send(cbm_pkg::OP_WRITE, 16'h2000, 8'h00);   // bank 0 maps to 1
    send(cbm_pkg::OP_WRITE, 16'h4000, 8'hE0);   // high bits in ROM mode
    send(cbm_pkg::OP_READ,  16'h7FFF, 8'hFF);
    send(cbm_pkg::OP_WRITE, 16'h6000, 8'h01);   // RAM banking mode
    send(cbm_pkg::OP_WRITE, 16'h5FFF, 8'hFF);   // RAM bank 3
    send(cbm_pkg::OP_READ,  16'hBFFF, 8'h00);
    send(cbm_pkg::OP_WRITE, 16'h0000, 8'h0A);   // RAM on
    send(cbm_pkg::OP_WRITE, 16'hE000, 8'hFF);   // echo, two beats
    send(cbm_pkg::OP_WRITE, 16'hFDFF, 8'h00);
    send(cbm_pkg::OP_WRITE, 16'h1FFF, 8'h05);   // other nibble keeps RAM state
    send(cbm_pkg::OP_WRITE, 16'h1FFF, 8'hF0);   // RAM off
    send(cbm_pkg::OP_WRITE, 16'hE123, 8'h55);   // echo dropped
    send(cbm_pkg::OP_WRITE, 16'hFEA0, 8'h12);   // restricted area
    send(cbm_pkg::OP_WRITE, 16'(cbm_pkg::DIVIDER_ADDR_DEF), 8'hFF);
    send(cbm_pkg::OP_WRITE, 16'(cbm_pkg::TIMER_CTRL_ADDR_DEF), 8'hAB);
    send(cbm_pkg::OP_WRITE, 16'hFFFF, 8'hFF);
    send(cbm_pkg::OP_WRITE, 16'h7FFF, 8'h00);   // back to ROM mode, RAM bank cleared
    send(cbm_pkg::OP_READ,  16'hA000, 8'h00);
    send(cbm_pkg::OP_READ,  16'hFFFF, 8'h00);
    drain();

    // MBC2: RAM enable gated by address bit 4, four-bit ROM bank
    configure(cbm_pkg::KIND_MBC2);
    send(cbm_pkg::OP_WRITE, 16'h0010, 8'h0A);
    send(cbm_pkg::OP_WRITE, 16'h0000, 8'h0A);
    send(cbm_pkg::OP_WRITE, 16'h3FFF, 8'hF0);
    send(cbm_pkg::OP_WRITE, 16'h5000, 8'hFF);
    drain();

    // spare code acts as no controller
    configure(KIND_SPARE);
    send(cbm_pkg::OP_WRITE, 16'h2000, 8'h07);
    send(cbm_pkg::OP_READ,  16'h4000, 8'h00);

    // random phases: three idling patterns, kinds cycling through all codes
    for (int p = 0; p < PHASES; p++) begin
      drain();
      configure(phase_kind[p]);
      case (p / 3)
        0: begin snd_idle = 11; rcv_idle = 71; end
        1: begin snd_idle = 71; rcv_idle = 11; end
        default: begin snd_idle = 0; rcv_idle = 0; end
      endcase
      // long receiver hold while the sender keeps offering
      if (p == 7) rcv_hold = 300;
      repeat (PHASE_ACCESSES) begin
        make_access(op, addr, data);
        send(op, addr, data);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
